### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NPBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/npbm_pkg.sv
// ============================================================================
// npbm_pkg
// Types, constants and codes of the binary netpbm stream decoder.
// ============================================================================
package npbm_pkg;

    // Default largest image dimension
    localparam int MAX_DIMENSION_DEF = 4096;

    // Fixed field widths
    localparam int COORD_W    = 12;
    localparam int LEVEL_W    = 8;
    localparam int DIVIDEND_W = 2 * LEVEL_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Header characters
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_SIX     = 8'h36;
    localparam logic [7:0] CH_FIVE    = 8'h35;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // Level cap for the maximum level header number
    localparam int LEVEL_CAP = 255;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LEVELS = 3'd4;

    // Color channel positions within a P6 pixel
    localparam logic [1:0] CHAN_RED   = 2'd0;
    localparam logic [1:0] CHAN_GREEN = 2'd1;
    localparam logic [1:0] CHAN_BLUE  = 2'd2;

    // Header parse phase
    typedef enum logic [3:0] {
        PH_MAGIC_P     = 4'd0,
        PH_MAGIC_KIND  = 4'd1,
        PH_MAGIC_TAIL  = 4'd2,
        PH_LINE_START  = 4'd3,
        PH_COMMENT     = 4'd4,
        PH_WIDTH       = 4'd5,
        PH_WIDTH_TAIL  = 4'd6,
        PH_HEIGHT      = 4'd7,
        PH_HEIGHT_TAIL = 4'd8,
        PH_LEVEL       = 4'd9,
        PH_LEVEL_TAIL  = 4'd10,
        PH_PIXELS      = 4'd11
    } phase_t;

    // Sample sequencer state
    typedef enum logic [1:0] {
        SQ_IDLE   = 2'd0,
        SQ_MUL    = 2'd1,
        SQ_DIV    = 2'd2,
        SQ_FINISH = 2'd3
    } seq_t;

    // Divider request and response
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [LEVEL_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quotient;
    } div_rsp_t;

endpackage

### rtl/npbm_in_if.sv
// ============================================================================
// npbm_in_if
// Byte stream channel: one file byte and its end-of-file mark per transfer.
// ============================================================================
interface npbm_in_if;
    import npbm_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] data_byte;
    logic               end_of_file;

    modport source (output valid, data_byte, end_of_file, input ready);
    modport sink   (input valid, data_byte, end_of_file, output ready);

endinterface

### rtl/npbm_out_if.sv
// ============================================================================
// npbm_out_if
// Pixel channel: one placed, scaled pixel per transfer.
// ============================================================================
interface npbm_out_if;
    import npbm_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;

    modport source (output valid, pixel_x, pixel_y, red, green, blue, input ready);
    modport sink   (input valid, pixel_x, pixel_y, red, green, blue, output ready);

endinterface

### rtl/npbm_div.sv
// ============================================================================
// npbm_div
// Radix-2 restoring divider, one quotient bit per cycle, shared by all samples.
// ============================================================================
module npbm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  npbm_pkg::div_req_t req,
    output npbm_pkg::div_rsp_t rsp
);
    import npbm_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DIVIDEND_W-1:0] work_reg, work_next;
    logic [LEVEL_W-1:0]    rem_reg, rem_next;
    logic [LEVEL_W-1:0]    divisor_reg, divisor_next;

    logic [LEVEL_W:0]      shifted;
    logic [LEVEL_W:0]      diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        shifted      = {rem_reg, work_reg[DIVIDEND_W-1]};
        diff         = shifted - {1'b0, divisor_reg};

        if (req.start)
        begin
            busy_next    = 1'b1;
            count_next   = '0;
            work_next    = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, divisor_reg})
            begin
                rem_next  = diff[LEVEL_W-1:0];
                work_next = {work_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[LEVEL_W-1:0];
                work_next = {work_reg[DIVIDEND_W-2:0], 1'b0};
            end
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    // Quotient fits the low bits since the sample is below the maximum level
    assign rsp.done     = done_reg;
    assign rsp.quotient = work_reg[LEVEL_W-1:0];

endmodule

### rtl/netpbm_stream_to_pixels_unit.sv
// ============================================================================
// netpbm_stream_to_pixels_unit
// Binary PGM (P5) / PPM (P6) stream decoder producing placed, scaled pixels.
// ============================================================================
// Usage:
//   stream  - sink of file bytes; end_of_file marks the last byte of a file,
//             after which the parser waits for a new magic line.
//   pixels  - source of placed pixels (gray repeated on all channels for P5).
//   cfg_*   - write port for origin, clip limits and output full scale; the
//             user must write it only while the block is idle (not enforced).
// Sequencing:
//   Header bytes and ignored bytes are taken without dropping ready.
//   A sample byte at or above the maximum level passes accept, multiply
//   and finish; any other passes accept, multiply, 16 radix-2 divider steps,
//   quotient pickup and finish. The block takes one byte at a time and drops
//   ready until that byte is finished.
//   A pixel leaves through an output register; the next byte is accepted while
//   it waits. If the receiver stalls, any sample holds in its finish step
//   until the register frees, and ready stays low meanwhile.
// Reset:
//   Parser returns to the magic line, registers take their reset values and
//   the output register empties.
// ============================================================================
module netpbm_stream_to_pixels_unit #(
    parameter int MAX_DIMENSION = npbm_pkg::MAX_DIMENSION_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    npbm_in_if.sink                        stream,
    npbm_out_if.source                     pixels,
    input  logic                           cfg_we,
    input  logic [npbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [npbm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import npbm_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int ACC_W = (DIM_W > LEVEL_W) ? DIM_W : LEVEL_W;
    localparam int MUL_W = ACC_W + 4;
    localparam int POS_W = ((DIM_W > COORD_W) ? DIM_W : COORD_W) + 1;
    localparam logic [MUL_W-1:0] DIM_CAP = MUL_W'(MAX_DIMENSION);
    localparam logic [MUL_W-1:0] LVL_CAP = MUL_W'(LEVEL_CAP);

    // Configuration registers
    logic [COORD_W-1:0] origin_x_reg, origin_y_reg, limit_x_reg, limit_y_reg;
    logic [LEVEL_W-1:0] out_levels_reg;

    // Parser state
    phase_t             phase_reg, phase_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [LEVEL_W-1:0] max_level_reg, max_level_next;
    logic               color_reg, color_next;
    logic [DIM_W-1:0]   col_reg, col_next;
    logic [DIM_W-1:0]   row_reg, row_next;
    logic [1:0]         chan_reg, chan_next;
    logic               stopped_reg, stopped_next;

    // Sample sequencer
    seq_t               sq_reg, sq_next;
    logic [LEVEL_W-1:0] sample_reg, sample_next;
    logic               eof_reg, eof_next;
    logic [LEVEL_W-1:0] value_reg, value_next;
    logic [LEVEL_W-1:0] red_hold_reg, red_hold_next;
    logic [LEVEL_W-1:0] green_hold_reg, green_hold_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [LEVEL_W-1:0] out_r_reg, out_r_next, out_g_reg, out_g_next;
    logic [LEVEL_W-1:0] out_b_reg, out_b_next;

    // Divider link
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // Header number helpers
    logic               accept;
    logic [7:0]         b;
    logic               is_digit;
    logic               level_phase;
    logic               width_phase;
    logic               tail_phase;
    logic [7:0]         delim;
    logic [ACC_W-1:0]   acc_eff;
    logic [MUL_W-1:0]   acc_x10;
    logic [MUL_W-1:0]   acc_capped;

    // Pixel placement helpers
    logic [POS_W-1:0]   x_sum, y_sum;
    logic [DIM_W-1:0]   col_inc, row_inc;

    assign accept = stream.valid && stream.ready;
    assign stream.ready = (sq_reg == SQ_IDLE);
    assign b = stream.data_byte;

    // Decimal accumulate with saturation
    always_comb
    begin
        is_digit    = b inside {[CH_ZERO:CH_NINE]};
        level_phase = phase_reg inside {PH_LEVEL, PH_LEVEL_TAIL};
        width_phase = phase_reg inside {PH_WIDTH, PH_WIDTH_TAIL, PH_LINE_START};
        tail_phase  = phase_reg inside {PH_WIDTH_TAIL, PH_HEIGHT_TAIL, PH_LEVEL_TAIL};
        delim       = width_phase ? CH_SPACE : CH_NEWLINE;
        acc_eff     = (phase_reg == PH_LINE_START) ? '0 : acc_reg;
        acc_x10     = {1'b0, acc_eff, 3'b000} + {3'b000, acc_eff, 1'b0}
                      + {{(MUL_W-4){1'b0}}, b[3:0]};
        if (level_phase)
            acc_capped = (acc_x10 > LVL_CAP) ? LVL_CAP : acc_x10;
        else
            acc_capped = (acc_x10 > DIM_CAP) ? DIM_CAP : acc_x10;
    end

    // Placement arithmetic
    assign x_sum   = POS_W'(origin_x_reg) + POS_W'(col_reg);
    assign y_sum   = POS_W'(origin_y_reg) + POS_W'(row_reg);
    assign col_inc = col_reg + 1'b1;
    assign row_inc = row_reg + 1'b1;

    // Parser and sequencer next state
    always_comb
    begin : seq_comb
        logic pixel_go;
        logic clear;
        logic do_pixel;
        logic [LEVEL_W-1:0] pr, pg, pb;

        pixel_go        = 1'b0;
        clear           = 1'b0;
        do_pixel        = 1'b0;
        pr              = value_reg;
        pg              = value_reg;
        pb              = value_reg;

        phase_next      = phase_reg;
        acc_next        = acc_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        max_level_next  = max_level_reg;
        color_next      = color_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        chan_next       = chan_reg;
        stopped_next    = stopped_reg;
        sq_next         = sq_reg;
        sample_next     = sample_reg;
        eof_next        = eof_reg;
        value_next      = value_reg;
        red_hold_next   = red_hold_reg;
        green_hold_next = green_hold_reg;
        div_req.start    = 1'b0;
        div_req.dividend = DIVIDEND_W'(sample_reg) * DIVIDEND_W'(out_levels_reg);
        div_req.divisor  = max_level_reg;

        out_valid_next  = out_valid_reg && !pixels.ready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_r_next      = out_r_reg;
        out_g_next      = out_g_reg;
        out_b_next      = out_b_reg;

        case (sq_reg)
            SQ_IDLE:
            begin
                if (accept && !stopped_reg)
                begin
                    case (phase_reg)
                        PH_MAGIC_P:
                        begin
                            if (b == CH_P)
                                phase_next = PH_MAGIC_KIND;
                            else
                                stopped_next = 1'b1;
                        end
                        PH_MAGIC_KIND:
                        begin
                            if (b == CH_SIX)
                            begin
                                color_next = 1'b1;
                                phase_next = PH_MAGIC_TAIL;
                            end
                            else if (b == CH_FIVE)
                            begin
                                color_next = 1'b0;
                                phase_next = PH_MAGIC_TAIL;
                            end
                            else
                                stopped_next = 1'b1;
                        end
                        PH_MAGIC_TAIL, PH_COMMENT:
                        begin
                            if (b == CH_NEWLINE)
                                phase_next = PH_LINE_START;
                        end
                        PH_LINE_START, PH_WIDTH, PH_WIDTH_TAIL, PH_HEIGHT,
                        PH_HEIGHT_TAIL, PH_LEVEL, PH_LEVEL_TAIL:
                        begin
                            if ((phase_reg == PH_LINE_START) && (b == CH_HASH))
                                phase_next = PH_COMMENT;
                            else if (b == delim)
                            begin
                                acc_next = '0;
                                if (width_phase)
                                begin
                                    width_next = acc_eff[DIM_W-1:0];
                                    phase_next = PH_HEIGHT;
                                end
                                else if (!level_phase)
                                begin
                                    height_next = acc_eff[DIM_W-1:0];
                                    phase_next  = PH_LEVEL;
                                end
                                else
                                begin
                                    max_level_next = acc_eff[LEVEL_W-1:0];
                                    phase_next     = PH_PIXELS;
                                    col_next       = '0;
                                    row_next       = '0;
                                    chan_next      = CHAN_RED;
                                    if ((acc_eff[LEVEL_W-1:0] == '0) || (width_reg == '0)
                                        || (height_reg == '0))
                                        stopped_next = 1'b1;
                                end
                            end
                            else if (!tail_phase && is_digit)
                            begin
                                acc_next = acc_capped[ACC_W-1:0];
                                if (phase_reg == PH_LINE_START)
                                    phase_next = PH_WIDTH;
                            end
                            else if (width_phase)
                            begin
                                acc_next   = acc_eff;
                                phase_next = PH_WIDTH_TAIL;
                            end
                            else if (level_phase)
                                phase_next = PH_LEVEL_TAIL;
                            else
                                phase_next = PH_HEIGHT_TAIL;
                        end
                        PH_PIXELS:
                        begin
                            pixel_go    = 1'b1;
                            sample_next = b;
                            eof_next    = stream.end_of_file;
                            sq_next     = SQ_MUL;
                        end
                        default:
                            stopped_next = 1'b1;
                    endcase
                end
                if (accept && stream.end_of_file && !pixel_go)
                    clear = 1'b1;
            end

            // Saturate, or hand the product to the divider
            SQ_MUL:
            begin
                if (sample_reg >= max_level_reg)
                begin
                    value_next = out_levels_reg;
                    sq_next    = SQ_FINISH;
                end
                else
                begin
                    div_req.start = 1'b1;
                    sq_next       = SQ_DIV;
                end
            end

            SQ_DIV:
            begin
                if (div_rsp.done)
                begin
                    value_next = div_rsp.quotient;
                    sq_next    = SQ_FINISH;
                end
            end

            // Gather channels, place and clip the pixel
            SQ_FINISH:
            begin
                if (!out_valid_reg || pixels.ready)
                begin
                    if (color_reg && (chan_reg == CHAN_RED))
                    begin
                        red_hold_next = value_reg;
                        chan_next     = CHAN_GREEN;
                    end
                    else if (color_reg && (chan_reg == CHAN_GREEN))
                    begin
                        green_hold_next = value_reg;
                        chan_next       = CHAN_BLUE;
                    end
                    else
                    begin
                        do_pixel  = 1'b1;
                        chan_next = CHAN_RED;
                        if (color_reg)
                        begin
                            pr = red_hold_reg;
                            pg = green_hold_reg;
                        end
                    end

                    if (do_pixel)
                    begin
                        if (y_sum > POS_W'(limit_y_reg))
                            stopped_next = 1'b1;
                        else
                        begin
                            if (x_sum <= POS_W'(limit_x_reg))
                            begin
                                out_valid_next = 1'b1;
                                out_x_next     = x_sum[COORD_W-1:0];
                                out_y_next     = y_sum[COORD_W-1:0];
                                out_r_next     = pr;
                                out_g_next     = pg;
                                out_b_next     = pb;
                            end
                            if (col_inc >= width_reg)
                            begin
                                col_next = '0;
                                row_next = row_inc;
                                if (row_inc >= height_reg)
                                    stopped_next = 1'b1;
                            end
                            else
                                col_next = col_inc;
                        end
                    end

                    clear   = eof_reg;
                    sq_next = SQ_IDLE;
                end
            end

            default:
                sq_next = SQ_IDLE;
        endcase

        // End of file: back to the magic line
        if (clear)
        begin
            phase_next     = PH_MAGIC_P;
            acc_next       = '0;
            width_next     = '0;
            height_next    = '0;
            max_level_next = '0;
            color_next     = 1'b0;
            col_next       = '0;
            row_next       = '0;
            chan_next      = CHAN_RED;
            stopped_next   = 1'b0;
        end
    end

    // Shared divider
    npbm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            limit_x_reg    <= '1;
            limit_y_reg    <= '1;
            out_levels_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORIGIN_X:   origin_x_reg   <= cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Y:   origin_y_reg   <= cfg_data[COORD_W-1:0];
                CFG_LIMIT_X:    limit_x_reg    <= cfg_data[COORD_W-1:0];
                CFG_LIMIT_Y:    limit_y_reg    <= cfg_data[COORD_W-1:0];
                CFG_OUT_LEVELS: out_levels_reg <= cfg_data[LEVEL_W-1:0];
                default:        ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAGIC_P;
            acc_reg       <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            max_level_reg <= '0;
            color_reg     <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            chan_reg      <= CHAN_RED;
            stopped_reg   <= 1'b0;
            sq_reg        <= SQ_IDLE;
            eof_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            max_level_reg <= max_level_next;
            color_reg     <= color_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            chan_reg      <= chan_next;
            stopped_reg   <= stopped_next;
            sq_reg        <= sq_next;
            eof_reg       <= eof_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        sample_reg     <= sample_next;
        value_reg      <= value_next;
        red_hold_reg   <= red_hold_next;
        green_hold_reg <= green_hold_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_r_reg      <= out_r_next;
        out_g_reg      <= out_g_next;
        out_b_reg      <= out_b_next;
    end

    assign pixels.valid   = out_valid_reg;
    assign pixels.pixel_x = out_x_reg;
    assign pixels.pixel_y = out_y_reg;
    assign pixels.red     = out_r_reg;
    assign pixels.green   = out_g_reg;
    assign pixels.blue    = out_b_reg;

endmodule

### rtl/npbm_checker.sv
// ============================================================================
// npbm_checker
// Port-level checks of the netpbm decoder, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module npbm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [npbm_pkg::COORD_W-1:0] out_x,
    input logic [npbm_pkg::COORD_W-1:0] out_y,
    input logic [npbm_pkg::LEVEL_W-1:0] out_r,
    input logic [npbm_pkg::LEVEL_W-1:0] out_g,
    input logic [npbm_pkg::LEVEL_W-1:0] out_b
);
    import npbm_pkg::*;

    // A stalled pixel stays offered
    `NPBM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "pixel dropped while stalled")

    // A stalled pixel keeps its payload
    `NPBM_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_x) && $stable(out_y) && $stable(out_r) && $stable(out_g) && $stable(out_b), "pixel changed while stalled")

    // Ready drops only right after an input transfer starts a sample
    `NPBM_ASSERT_IMP(a_ready_fall, clk, rst_n, $fell(in_ready), $past(in_valid && in_ready), "ready fell without a transfer")

    // A new pixel appears only from a sample in progress
    `NPBM_ASSERT_IMP(a_pix_busy, clk, rst_n, $rose(out_valid), !$past(in_ready), "pixel without work")

endmodule

bind netpbm_stream_to_pixels_unit npbm_checker u_npbm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stream.valid),
    .in_ready  (stream.ready),
    .out_valid (pixels.valid),
    .out_ready (pixels.ready),
    .out_x     (pixels.pixel_x),
    .out_y     (pixels.pixel_y),
    .out_r     (pixels.red),
    .out_g     (pixels.green),
    .out_b     (pixels.blue)
);

### dv/tb_netpbm_stream_to_pixels_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_netpbm_stream_to_pixels_unit
// Streams binary P5/P6 files, valid and broken, into the decoder one byte per
// transfer. A built-in decoder predicts each placed pixel, and every pixel
// transfer is checked in order against it. The run covers several window and
// scale settings, random sender gaps, receiver stalls and one long hold-off.
// ============================================================================
module tb_netpbm_stream_to_pixels_unit;
    import npbm_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    // Idle time after the last expected pixel, before config writes
    localparam int DRAIN_CYCLES = 48;
    localparam int HOLD_CYCLES  = 600;
    // Generous bound on the whole run: all bytes, hold-offs and drains
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [LEVEL_W-1:0] r;
        logic [LEVEL_W-1:0] g;
        logic [LEVEL_W-1:0] b;
    } pixel_t;

    typedef enum int {
        RX_STEADY,
        RX_MOSTLY,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    npbm_in_if  stream_if ();
    npbm_out_if pixel_if ();

    netpbm_stream_to_pixels_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_if),
        .pixels    (pixel_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Decoder state kept by the predictor
    phase_t      dec_phase;
    int unsigned dec_accum;
    int unsigned img_w;
    int unsigned img_h;
    int unsigned img_max;
    bit          img_color;
    int unsigned col_n;
    int unsigned row_n;
    logic [1:0]  chan_n;
    logic [7:0]  red_keep;
    logic [7:0]  green_keep;
    bit          dec_halted;

    // Window and scale as last written
    int unsigned win_org_x;
    int unsigned win_org_y;
    int unsigned win_lim_x;
    int unsigned win_lim_y;
    int unsigned full_scale;

    pixel_t      expected_pixels[$];
    logic [7:0]  file_bytes[$];

    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned items_sent;
    int unsigned burst_left;
    int unsigned tx_gap_max;
    rx_mode_t    rx_mode;
    bit          hold_request;
    int unsigned hold_left;
    int unsigned rx_tick;

    // Clock
    always #(CLK_HALF) clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void restart_decoder();
        dec_phase  = PH_MAGIC_P;
        dec_accum  = 0;
        img_w      = 0;
        img_h      = 0;
        img_max    = 0;
        img_color  = 1'b0;
        col_n      = 0;
        row_n      = 0;
        chan_n     = CHAN_RED;
        red_keep   = '0;
        green_keep = '0;
        dec_halted = 1'b0;
    endfunction

    // One header number byte; returns 1 on the delimiter
    function automatic bit take_digit(logic [7:0] b, logic [7:0] delim, int unsigned cap,
                                      phase_t tail);
        int unsigned v;
        if (b == delim)
            return 1'b1;
        if (dec_phase != tail && b >= CH_ZERO && b <= CH_NINE)
        begin
            v = dec_accum * 10 + (b - CH_ZERO);
            dec_accum = (v > cap) ? cap : v;
        end
        else
            dec_phase = tail;
        return 1'b0;
    endfunction

    function automatic logic [7:0] scale_level(logic [7:0] s);
        int unsigned prod;
        if (s >= img_max)
            return full_scale[7:0];
        prod = s * full_scale;
        prod = prod / img_max;
        return prod[7:0];
    endfunction

    // Place a finished pixel; returns 1 if it lands inside the window
    function automatic bit place_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       output pixel_t p);
        int unsigned x;
        int unsigned y;
        bit          shown;
        p = '0;
        shown = 1'b0;
        x = win_org_x + col_n;
        y = win_org_y + row_n;
        if (y > win_lim_y)
        begin
            dec_halted = 1'b1;
            return 1'b0;
        end
        if (x <= win_lim_x)
        begin
            p.px = x[11:0];
            p.py = y[11:0];
            p.r  = r;
            p.g  = g;
            p.b  = b;
            shown = 1'b1;
        end
        col_n++;
        if (col_n >= img_w)
        begin
            col_n = 0;
            row_n++;
            if (row_n >= img_h)
                dec_halted = 1'b1;
        end
        return shown;
    endfunction

    // One file byte; returns 1 when a pixel is due
    function automatic bit decode_byte(logic [7:0] b, output pixel_t p);
        logic [7:0] lv;
        p = '0;
        if (dec_halted)
            return 1'b0;
        if (dec_phase == PH_MAGIC_P)
        begin
            if (b == CH_P)
                dec_phase = PH_MAGIC_KIND;
            else
                dec_halted = 1'b1;
            return 1'b0;
        end
        if (dec_phase == PH_MAGIC_KIND)
        begin
            if (b == CH_SIX)
                img_color = 1'b1;
            else if (b == CH_FIVE)
                img_color = 1'b0;
            else
            begin
                dec_halted = 1'b1;
                return 1'b0;
            end
            dec_phase = PH_MAGIC_TAIL;
            return 1'b0;
        end
        if (dec_phase == PH_MAGIC_TAIL || dec_phase == PH_COMMENT)
        begin
            if (b == CH_NEWLINE)
                dec_phase = PH_LINE_START;
            return 1'b0;
        end
        // A line start either opens a comment or begins the width
        if (dec_phase == PH_LINE_START)
        begin
            if (b == CH_HASH)
            begin
                dec_phase = PH_COMMENT;
                return 1'b0;
            end
            dec_phase = PH_WIDTH;
            dec_accum = 0;
        end
        if (dec_phase == PH_WIDTH || dec_phase == PH_WIDTH_TAIL)
        begin
            if (take_digit(b, CH_SPACE, MAX_DIMENSION_DEF, PH_WIDTH_TAIL))
            begin
                img_w     = dec_accum;
                dec_accum = 0;
                dec_phase = PH_HEIGHT;
            end
            return 1'b0;
        end
        if (dec_phase == PH_HEIGHT || dec_phase == PH_HEIGHT_TAIL)
        begin
            if (take_digit(b, CH_NEWLINE, MAX_DIMENSION_DEF, PH_HEIGHT_TAIL))
            begin
                img_h     = dec_accum;
                dec_accum = 0;
                dec_phase = PH_LEVEL;
            end
            return 1'b0;
        end
        if (dec_phase == PH_LEVEL || dec_phase == PH_LEVEL_TAIL)
        begin
            if (take_digit(b, CH_NEWLINE, LEVEL_CAP, PH_LEVEL_TAIL))
            begin
                img_max   = dec_accum;
                dec_accum = 0;
                dec_phase = PH_PIXELS;
                col_n     = 0;
                row_n     = 0;
                chan_n    = CHAN_RED;
                if (img_max == 0 || img_w == 0 || img_h == 0)
                    dec_halted = 1'b1;
            end
            return 1'b0;
        end
        if (dec_phase == PH_PIXELS)
        begin
            lv = scale_level(b);
            if (!img_color)
                return place_pixel(lv, lv, lv, p);
            if (chan_n == CHAN_RED)
            begin
                red_keep = lv;
                chan_n   = CHAN_GREEN;
                return 1'b0;
            end
            if (chan_n == CHAN_GREEN)
            begin
                green_keep = lv;
                chan_n     = CHAN_BLUE;
                return 1'b0;
            end
            chan_n = CHAN_RED;
            return place_pixel(red_keep, green_keep, lv, p);
        end
        dec_halted = 1'b1;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Byte sender
    // ------------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b, bit eof);
        pixel_t      p;
        int unsigned gap;
        stream_if.valid       <= 1'b1;
        stream_if.data_byte   <= b;
        stream_if.end_of_file <= eof;
        do
            @(posedge clk);
        while (!stream_if.ready);
        // transfer done at this edge
        items_sent++;
        if (decode_byte(b, p))
            expected_pixels.push_back(p);
        if (eof)
            restart_decoder();
        // bursts of random length with random gaps
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap != 0)
            begin
                stream_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    // Wait for every pending pixel, then let the block settle
    task automatic wait_idle();
        stream_if.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_window(int unsigned ox, int unsigned oy, int unsigned lx,
                              int unsigned ly, int unsigned lv);
        wait_idle();
        write_reg(CFG_ORIGIN_X, ox[11:0]);
        write_reg(CFG_ORIGIN_Y, oy[11:0]);
        write_reg(CFG_LIMIT_X, lx[11:0]);
        write_reg(CFG_LIMIT_Y, ly[11:0]);
        write_reg(CFG_OUT_LEVELS, {4'd0, lv[7:0]});
        cfg_we     <= 1'b0;
        win_org_x  = ox & 32'hFFF;
        win_org_y  = oy & 32'hFFF;
        win_lim_x  = lx & 32'hFFF;
        win_lim_y  = ly & 32'hFFF;
        full_scale = lv & 32'hFF;
    endtask

    // ------------------------------------------------------------------------
    // File building
    // ------------------------------------------------------------------------
    function automatic void add_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            file_bytes.push_back(s[i]);
    endfunction

    function automatic void add_junk(int unsigned count, logic [7:0] avoid);
        logic [7:0] b;
        repeat (count)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == avoid);
            file_bytes.push_back(b);
        end
    endfunction

    // Header number: sometimes empty, zero-padded or followed by junk
    function automatic void add_header_number(int unsigned n, logic [7:0] delim);
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel != 0)
        begin
            if (sel == 1)
                file_bytes.push_back(CH_ZERO);
            add_text($sformatf("%0d", n));
            if (sel == 2)
                add_junk($urandom_range(1, 3), delim);
        end
        file_bytes.push_back(delim);
    endfunction

    function automatic void build_random_file();
        int unsigned kind;
        int unsigned sel;
        int unsigned w;
        int unsigned h;
        int unsigned lvl;
        int unsigned n;
        int unsigned n_comments;
        int unsigned new_size;
        bit          color;
        logic [7:0]  b;
        file_bytes.delete();
        color = 1'($urandom_range(0, 1));
        kind  = $urandom_range(0, 99);

        // magic line, mostly well formed
        if (kind < 4)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_P);
            file_bytes.push_back(b);
        end
        else
            file_bytes.push_back(CH_P);
        if (kind >= 4 && kind < 8)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_SIX || b == CH_FIVE);
            file_bytes.push_back(b);
        end
        else
            file_bytes.push_back(color ? CH_SIX : CH_FIVE);
        if ($urandom_range(0, 3) == 0)
            add_junk($urandom_range(1, 2), CH_NEWLINE);
        file_bytes.push_back(CH_NEWLINE);

        // comment lines
        n_comments = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n_comments)
        begin
            file_bytes.push_back(CH_HASH);
            add_junk($urandom_range(0, 4), CH_NEWLINE);
            file_bytes.push_back(CH_NEWLINE);
        end

        // dimensions: mostly small, sometimes zero or saturating
        sel = $urandom_range(0, 19);
        w = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(4000, 70000) : $urandom_range(1, 6);
        sel = $urandom_range(0, 19);
        h = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(4000, 70000) : $urandom_range(1, 5);
        sel = $urandom_range(0, 19);
        lvl = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(256, 999) :
              (sel < 7) ? $urandom_range(1, 15) : $urandom_range(16, 255);
        add_header_number(w, CH_SPACE);
        add_header_number(h, CH_NEWLINE);
        add_header_number(lvl, CH_NEWLINE);

        // samples: a whole image, or short, or with extra bytes
        n = (w > 8 ? 8 : w) * (h > 8 ? 8 : h) * (color ? 3 : 1);
        if (n == 0)
            n = $urandom_range(0, 4);
        sel = $urandom_range(0, 9);
        if (sel == 0)
            n += $urandom_range(1, 4);
        else if (sel == 1 && n > 2)
            n -= $urandom_range(1, 2);
        if (lvl > 255)
            lvl = 255;
        repeat (n)
        begin
            b = 8'($urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, lvl));
            file_bytes.push_back(b);
        end

        // file cut short by end of file, in the header or in the samples
        if (kind >= 8 && kind < 11)
        begin
            new_size = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > new_size)
                void'(file_bytes.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: own stall pattern, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rx_tick++;
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (!rst_n)
            pixel_if.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            pixel_if.ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_STEADY:   pixel_if.ready <= 1'b1;
                RX_MOSTLY:   pixel_if.ready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: pixel_if.ready <= ((rx_tick % 9) < 5);
                default:     pixel_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pixel checker
    // ------------------------------------------------------------------------
    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
            note_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
    endfunction

    always @(posedge clk)
    begin : check_pixels
        pixel_t want;
        if (rst_n && pixel_if.valid && pixel_if.ready)
        begin
            if (expected_pixels.size() == 0)
                note_mismatch($sformatf("unexpected pixel at (%0d,%0d)",
                                        pixel_if.pixel_x, pixel_if.pixel_y));
            else
            begin
                want = expected_pixels.pop_front();
                check_field("pixel_x", want.px, pixel_if.pixel_x);
                check_field("pixel_y", want.py, pixel_if.pixel_y);
                check_field("red", want.r, pixel_if.red);
                check_field("green", want.g, pixel_if.green);
                check_field("blue", want.b, pixel_if.blue);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Wrong first byte, then wrong kind byte: both files yield nothing
    task automatic test_bad_magic();
        tx_gap_max = 0;
        rx_mode    = RX_STEADY;
        file_bytes.delete();
        add_text("Q6");
        send_file();
        file_bytes.delete();
        add_text("P4");
        send_file();
    endtask

    // Gray file with a comment line, darkest and brightest samples
    task automatic test_gray_file();
        file_bytes.delete();
        add_text("P5\n#\n2 1\n255\n");
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        send_file();
    endtask

    // Color pixel with a scaled, a full and a saturating sample
    task automatic test_color_file();
        tx_gap_max = 3;
        rx_mode    = RX_MOSTLY;
        file_bytes.delete();
        add_text("P6\n1 1\n8\n");
        file_bytes.push_back(8'h04);
        file_bytes.push_back(8'h08);
        file_bytes.push_back(8'hFF);
        send_file();
    endtask

    // Receiver holds off long while the sender keeps offering bytes
    task automatic test_receiver_hold();
        tx_gap_max   = 0;
        rx_mode      = RX_STEADY;
        hold_request = 1'b1;
        file_bytes.delete();
        add_text("P5\n8 4\n200\n");
        repeat (32) file_bytes.push_back(8'($urandom_range(0, 255)));
        send_file();
    endtask

    // Random files until about count more bytes went through
    task automatic test_random_files(int unsigned count);
        int unsigned target;
        int unsigned pick;
        target = items_sent + count;
        while (items_sent < target)
        begin
            build_random_file();
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            pick = $urandom_range(0, 2);
            tx_gap_max = (pick == 0) ? 0 : (pick == 1) ? 3 : 30;
            send_file();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_ORIGIN_X;
        cfg_data              = '0;
        stream_if.valid       = 1'b0;
        stream_if.data_byte   = '0;
        stream_if.end_of_file = 1'b0;
        pixel_if.ready        = 1'b0;
        mismatches            = 0;
        cycle_count           = 0;
        items_sent            = 0;
        burst_left            = 0;
        tx_gap_max            = 0;
        rx_mode               = RX_STEADY;
        hold_request          = 1'b0;
        hold_left             = 0;
        rx_tick               = 0;
        win_org_x             = 0;
        win_org_y             = 0;
        win_lim_x             = 4095;
        win_lim_y             = 4095;
        full_scale            = 255;
        restart_decoder();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bad_magic();
        test_gray_file();
        test_color_file();
        test_receiver_hold();

        set_window(0, 0, 4095, 4095, 255);
        test_random_files(350);
        // far corner: only the first column of the first row fits
        set_window(4095, 4095, 4095, 4095, 1);
        test_random_files(80);
        // single-pixel window at the origin
        set_window(0, 0, 0, 0, 255);
        test_random_files(80);
        // small window that clips columns and rows
        set_window(2, 1, 5, 3, $urandom_range(1, 255));
        test_random_files(200);
        set_window($urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(1, 255));
        test_random_files(60);
        set_window($urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(1, 255));
        test_random_files(60);
        set_window($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(2, 9),
                   $urandom_range(1, 6), $urandom_range(1, 255));
        test_random_files(150);

        wait_idle();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/npbm_pkg.sv
rtl/npbm_in_if.sv
rtl/npbm_out_if.sv
rtl/npbm_div.sv
rtl/netpbm_stream_to_pixels_unit.sv
rtl/npbm_checker.sv
dv/tb_netpbm_stream_to_pixels_unit.sv
